FILE: src/roi_gray_statistics_unit_macros.svh
// ---------------------------------------------------------------------------
// ROI gray statistics assertion macros
// Concurrent assertion wrappers that compile away for synthesis.
// ---------------------------------------------------------------------------
`ifndef ROI_GRAY_STATISTICS_UNIT_MACROS_SVH
`define ROI_GRAY_STATISTICS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ROI_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ROI_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ROI_ASSERT(lbl, clk, rst, prop, msg)
`define ROI_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

FILE: src/roi_gs_pkg.sv
// ---------------------------------------------------------------------------
// ROI gray statistics package
// Widths, register indexes, constants and shared types.
// ---------------------------------------------------------------------------
package roi_gs_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COORD_BITS   = 12;
  localparam int MAX_CHANNELS = 4;
  localparam int VAL_BITS     = 17;
  localparam int TOT_BITS     = 19;
  localparam int MAG_BITS     = 18;
  localparam int SUM_BITS     = 41;
  localparam int SQ_BITS      = 57;
  localparam int CNT_BITS     = 25;
  localparam int DIM_BITS     = 13;
  localparam int CC_BITS      = 3;
  localparam int MEAN_BITS    = 25;
  localparam int DEV_BITS     = 24;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROI_LEFT       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROI_TOP        = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROI_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROI_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SKIP_ALPHA     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SIGNED_SAMPLES = 3'd6;

  // Reciprocal of three, scaled by 2^20; exact floor for magnitudes below 2^18.
  localparam int              RECIP3_BITS  = 19;
  localparam int              RECIP3_SHIFT = 20;
  localparam logic [RECIP3_BITS-1:0] RECIP3 = 19'd349526;

  localparam logic signed [VAL_BITS-1:0] RUN_MIN_INIT = 17'sd65535;
  localparam logic signed [VAL_BITS-1:0] RUN_MAX_INIT = -17'sd32768;

  typedef logic signed [VAL_BITS-1:0] val_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic [SUM_BITS-1:0] sum;
    logic [SQ_BITS-1:0]  sq;
    val_t                mn;
    val_t                mx;
  } roi_snap_t;

endpackage

FILE: src/roi_gs_ifs.sv
// ---------------------------------------------------------------------------
// ROI gray statistics channel interfaces
// Pixel input, result output and register write channels.
// ---------------------------------------------------------------------------
interface roi_pix_if import roi_gs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic [SAMPLE_BITS-1:0] sample_b;
  logic [SAMPLE_BITS-1:0] sample_c;
  logic [SAMPLE_BITS-1:0] sample_d;
  logic                   end_of_line;
  logic                   end_of_frame;
  modport source (output valid, sample_a, sample_b, sample_c, sample_d, end_of_line,
                  end_of_frame, input ready);
  modport sink (input valid, sample_a, sample_b, sample_c, sample_d, end_of_line,
                end_of_frame, output ready);
endinterface

interface roi_res_if import roi_gs_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [MEAN_BITS-1:0] mean_q8;
  logic [DEV_BITS-1:0]         stdev_q8;
  logic signed [VAL_BITS-1:0]  min_value;
  logic signed [VAL_BITS-1:0]  max_value;
  logic [CNT_BITS-1:0]         pixel_total;
  logic                        roi_empty;
  modport source (output valid, mean_q8, stdev_q8, min_value, max_value, pixel_total,
                  roi_empty, input ready);
  modport sink (input valid, mean_q8, stdev_q8, min_value, max_value, pixel_total,
                roi_empty, output ready);
endinterface

interface roi_cfg_if import roi_gs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/roi_gs_lane.sv
// ---------------------------------------------------------------------------
// ROI gray statistics channel lane
// Decodes one channel sample and offers it to the sum and min/max merge.
// ---------------------------------------------------------------------------
module roi_gs_lane import roi_gs_pkg::*; (
  input  logic                   clk,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] raw,
  input  logic                   signed_mode,
  input  logic                   en,
  output val_t                   val,
  output val_t                   lo,
  output val_t                   hi
);

  val_t v_r;
  logic en_r;

  always_ff @(posedge clk) begin
    if (load) begin
      v_r  <= signed_mode ? val_t'({raw[SAMPLE_BITS-1], raw}) : val_t'({1'b0, raw});
      en_r <= en;
    end
  end

  // A disabled lane adds nothing and never wins a compare.
  assign val = en_r ? v_r : '0;
  assign lo  = en_r ? v_r : RUN_MIN_INIT;
  assign hi  = en_r ? v_r : RUN_MAX_INIT;

endmodule

FILE: src/roi_gs_merge.sv
// ---------------------------------------------------------------------------
// ROI gray statistics merge and accumulate
// Combines lane samples into the pixel average and keeps the frame sums.
// ---------------------------------------------------------------------------
module roi_gs_merge import roi_gs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic             inroi,
  input  logic             eof,
  input  logic [CC_BITS-1:0] used,
  input  val_t             lane_val [MAX_CHANNELS],
  input  val_t             lane_lo [MAX_CHANNELS],
  input  val_t             lane_hi [MAX_CHANNELS],
  output logic             eof_busy,
  output logic             start,
  output roi_snap_t        snap
);

  localparam int PROD_BITS = MAG_BITS + RECIP3_BITS;

  logic               s1_valid, s1_inroi, s1_eof;
  logic [CC_BITS-1:0] s1_used;
  logic               s2_valid, s2_inroi, s2_eof, s2_neg;
  logic [CC_BITS-1:0] s2_used;
  logic [MAG_BITS-1:0] s2_mag;
  val_t               s2_min, s2_max;
  logic               s3_valid, s3_inroi, s3_eof, s3_neg;
  logic [VAL_BITS-1:0] s3_q;
  val_t               s3_min, s3_max;

  logic signed [TOT_BITS-1:0] total;
  logic [MAG_BITS-1:0]        tmag;
  val_t                       min01, min23, max01, max23, pmin, pmax;
  logic [PROD_BITS-1:0]       prod3;
  logic [MAG_BITS-1:0]        qsel;

  logic [SUM_BITS-1:0] average_sum, sum_new;
  logic [SQ_BITS-1:0]  square_sum, sq_new;
  logic [CNT_BITS-1:0] pixel_counter, cnt_new;
  val_t                running_min, running_max, min_new, max_new;
  logic [SUM_BITS-1:0] avg_ext;
  logic [2*VAL_BITS-1:0] qsq;

  always_comb begin
    total = '0;
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      total = total + TOT_BITS'(lane_val[k]);
    end
  end

  assign tmag  = total[TOT_BITS-1] ? MAG_BITS'(-total) : MAG_BITS'(total);
  assign min01 = (lane_lo[0] < lane_lo[1]) ? lane_lo[0] : lane_lo[1];
  assign min23 = (lane_lo[2] < lane_lo[3]) ? lane_lo[2] : lane_lo[3];
  assign max01 = (lane_hi[0] > lane_hi[1]) ? lane_hi[0] : lane_hi[1];
  assign max23 = (lane_hi[2] > lane_hi[3]) ? lane_hi[2] : lane_hi[3];
  assign pmin  = (min01 < min23) ? min01 : min23;
  assign pmax  = (max01 > max23) ? max01 : max23;

  assign prod3 = PROD_BITS'(s2_mag) * PROD_BITS'(RECIP3);

  always_comb begin
    case (s2_used)
      3'd2:    qsel = s2_mag >> 1;
      3'd3:    qsel = MAG_BITS'(prod3 >> RECIP3_SHIFT);
      3'd4:    qsel = s2_mag >> 2;
      default: qsel = s2_mag;
    endcase
  end

  assign avg_ext = s3_neg ? -SUM_BITS'({1'b0, s3_q}) : SUM_BITS'({1'b0, s3_q});
  assign qsq     = (2*VAL_BITS)'(s3_q) * (2*VAL_BITS)'(s3_q);

  always_comb begin
    sum_new = average_sum;
    sq_new  = square_sum;
    cnt_new = pixel_counter;
    min_new = running_min;
    max_new = running_max;
    if (s3_valid && s3_inroi) begin
      sum_new = average_sum + avg_ext;
      sq_new  = square_sum + SQ_BITS'(qsq);
      cnt_new = pixel_counter + 1'b1;
      min_new = (s3_min < running_min) ? s3_min : running_min;
      max_new = (s3_max > running_max) ? s3_max : running_max;
    end
  end

  assign start      = s3_valid && s3_eof;
  assign snap.count = cnt_new;
  assign snap.sum   = sum_new;
  assign snap.sq    = sq_new;
  assign snap.mn    = min_new;
  assign snap.mx    = max_new;
  assign eof_busy   = (s1_valid && s1_eof) || (s2_valid && s2_eof) || (s3_valid && s3_eof);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      average_sum   <= '0;
      square_sum    <= '0;
      pixel_counter <= '0;
      running_min   <= RUN_MIN_INIT;
      running_max   <= RUN_MAX_INIT;
    end else begin
      s1_valid <= load;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      // The end-of-frame beat hands its totals over and starts a fresh frame.
      if (start) begin
        average_sum   <= '0;
        square_sum    <= '0;
        pixel_counter <= '0;
        running_min   <= RUN_MIN_INIT;
        running_max   <= RUN_MAX_INIT;
      end else begin
        average_sum   <= sum_new;
        square_sum    <= sq_new;
        pixel_counter <= cnt_new;
        running_min   <= min_new;
        running_max   <= max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_inroi <= inroi;
      s1_eof   <= eof;
      s1_used  <= used;
    end
    s2_inroi <= s1_inroi;
    s2_eof   <= s1_eof;
    s2_used  <= s1_used;
    s2_neg   <= total[TOT_BITS-1];
    s2_mag   <= tmag;
    s2_min   <= pmin;
    s2_max   <= pmax;
    s3_inroi <= s2_inroi;
    s3_eof   <= s2_eof;
    s3_neg   <= s2_neg;
    s3_q     <= VAL_BITS'(qsel);
    s3_min   <= s2_min;
    s3_max   <= s2_max;
  end

endmodule

FILE: src/roi_gs_finish.sv
// ---------------------------------------------------------------------------
// ROI gray statistics frame finisher
// Serial multiply, divide and square root for mean and deviation.
// ---------------------------------------------------------------------------
`include "roi_gray_statistics_unit_macros.svh"

module roi_gs_finish import roi_gs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  roi_snap_t snap,
  output logic      busy,
  roi_res_if.source res
);

  localparam int MUL_W  = SQ_BITS + CNT_BITS;
  localparam int MULB_W = SUM_BITS;
  localparam int DIV_W  = MUL_W + 16;
  localparam int DEN_W  = 2 * CNT_BITS;
  localparam int SQ_W   = 2 * DEV_BITS;
  localparam int CNT_W  = 7;

  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MULB_W - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(DEV_BITS - 1);
  localparam logic [SQ_W-1:0]  SQRT_BIT0 = SQ_W'(1) << (SQ_W - 2);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIVM = 3'd1;
  localparam logic [2:0] F_MUL1 = 3'd2;
  localparam logic [2:0] F_MUL2 = 3'd3;
  localparam logic [2:0] F_MUL3 = 3'd4;
  localparam logic [2:0] F_DIVV = 3'd5;
  localparam logic [2:0] F_SQRT = 3'd6;
  localparam logic [2:0] F_DONE = 3'd7;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;

  logic [CNT_BITS-1:0] n_r;
  logic [SUM_BITS-1:0] smag;
  logic                neg_r;
  logic [SQ_BITS-1:0]  sq_r;
  val_t                mn_r, mx_r;
  logic                empty_r;
  logic [MEAN_BITS-1:0] mean_r;
  logic [DEV_BITS-1:0]  dev_r;

  logic [MUL_W-1:0]  mul_a, mul_acc, nq;
  logic [MULB_W-1:0] mul_b;
  logic [MUL_W-1:0]  acc_next;

  logic [DIV_W-1:0]   div_num, num_next;
  logic [DEN_W-1:0]   div_den, rem_next, div_rem;
  logic [DEN_W:0]     div_t;
  logic               div_ge;

  logic [SQ_W-1:0] sq_v, sq_res, sq_bit, res_next;
  logic [SQ_W:0]   sq_t;
  logic            sq_ge;

  logic [SUM_BITS-1:0]  in_smag;
  logic [MEAN_BITS-1:0] qm;
  logic                 out_valid, out_free;

  assign in_smag  = snap.sum[SUM_BITS-1] ? (~snap.sum + 1'b1) : snap.sum;
  assign acc_next = mul_b[0] ? mul_acc + mul_a : mul_acc;

  assign div_t    = {div_rem, div_num[DIV_W-1]};
  assign div_ge   = div_t >= {1'b0, div_den};
  assign rem_next = div_ge ? DEN_W'(div_t - {1'b0, div_den}) : DEN_W'(div_t);
  assign num_next = {div_num[DIV_W-2:0], div_ge};
  assign qm       = num_next[MEAN_BITS-1:0];

  assign sq_t     = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_ge    = {1'b0, sq_v} >= sq_t;
  assign res_next = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;

  assign busy      = state != F_IDLE;
  assign out_free  = !out_valid || res.ready;
  assign res.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == F_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        F_IDLE: begin
          if (start) begin
            state <= (snap.count == '0) ? F_DONE : F_DIVM;
          end
        end
        F_DIVM: begin
          if (cnt == '0) begin
            state <= (n_r == CNT_BITS'(1)) ? F_DONE : F_MUL1;
          end
        end
        F_MUL1: begin
          if (cnt == '0) begin
            state <= F_MUL2;
          end
        end
        F_MUL2: begin
          if (cnt == '0) begin
            state <= (nq >= acc_next) ? F_MUL3 : F_DONE;
          end
        end
        F_MUL3: begin
          if (cnt == '0) begin
            state <= F_DIVV;
          end
        end
        F_DIVV: begin
          if (cnt == '0) begin
            state <= (|num_next[DIV_W-1:SQ_W]) ? F_DONE : F_SQRT;
          end
        end
        F_SQRT: begin
          if (cnt == '0) begin
            state <= F_DONE;
          end
        end
        F_DONE: begin
          if (out_free) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        n_r     <= snap.count;
        smag    <= in_smag;
        neg_r   <= snap.sum[SUM_BITS-1];
        sq_r    <= snap.sq;
        mn_r    <= snap.mn;
        mx_r    <= snap.mx;
        empty_r <= snap.count == '0;
        mean_r  <= '0;
        dev_r   <= '0;
        div_num <= {{(DIV_W-SUM_BITS-8){1'b0}}, in_smag, 8'b0};
        div_den <= {{(DEN_W-CNT_BITS){1'b0}}, snap.count};
        div_rem <= '0;
        cnt     <= DIV_LAST;
      end
      F_DIVM: begin
        if (cnt == '0) begin
          mean_r  <= neg_r ? (~qm + 1'b1) : qm;
          mul_a   <= {{(MUL_W-SQ_BITS){1'b0}}, sq_r};
          mul_b   <= {{(MULB_W-CNT_BITS){1'b0}}, n_r};
          mul_acc <= '0;
          cnt     <= MUL_LAST;
        end else begin
          cnt     <= cnt - 1'b1;
          div_num <= num_next;
          div_rem <= rem_next;
        end
      end
      F_MUL1: begin
        if (cnt == '0) begin
          nq      <= acc_next;
          mul_a   <= {{(MUL_W-SUM_BITS){1'b0}}, smag};
          mul_b   <= smag;
          mul_acc <= '0;
          cnt     <= MUL_LAST;
        end else begin
          cnt     <= cnt - 1'b1;
          mul_acc <= acc_next;
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
        end
      end
      F_MUL2: begin
        if (cnt == '0) begin
          nq      <= nq - acc_next;
          mul_a   <= {{(MUL_W-CNT_BITS){1'b0}}, n_r};
          mul_b   <= {{(MULB_W-CNT_BITS){1'b0}}, n_r - 1'b1};
          mul_acc <= '0;
          cnt     <= MUL_LAST;
        end else begin
          cnt     <= cnt - 1'b1;
          mul_acc <= acc_next;
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
        end
      end
      F_MUL3: begin
        if (cnt == '0) begin
          div_num <= {nq, 16'b0};
          div_den <= acc_next[DEN_W-1:0];
          div_rem <= '0;
          cnt     <= DIV_LAST;
        end else begin
          cnt     <= cnt - 1'b1;
          mul_acc <= acc_next;
          mul_a   <= mul_a << 1;
          mul_b   <= mul_b >> 1;
        end
      end
      F_DIVV: begin
        if (cnt == '0) begin
          // A quotient of 2^48 or more has a root that no longer fits the field.
          dev_r  <= '1;
          sq_v   <= num_next[SQ_W-1:0];
          sq_res <= '0;
          sq_bit <= SQRT_BIT0;
          cnt    <= SQRT_LAST;
        end else begin
          cnt     <= cnt - 1'b1;
          div_num <= num_next;
          div_rem <= rem_next;
        end
      end
      F_SQRT: begin
        if (cnt == '0) begin
          dev_r <= res_next[DEV_BITS-1:0];
        end else begin
          cnt    <= cnt - 1'b1;
          sq_v   <= sq_ge ? sq_v - sq_t[SQ_W-1:0] : sq_v;
          sq_res <= res_next;
          sq_bit <= sq_bit >> 2;
        end
      end
      F_DONE: begin
        if (out_free) begin
          res.mean_q8     <= empty_r ? '0 : mean_r;
          res.stdev_q8    <= empty_r ? '0 : dev_r;
          res.min_value   <= empty_r ? '0 : mn_r;
          res.max_value   <= empty_r ? '0 : mx_r;
          res.pixel_total <= n_r;
          res.roi_empty   <= empty_r;
        end
      end
      default: ;
    endcase
  end

  `ROI_ASSERT(a_start_idle, clk, rst, start |-> state == F_IDLE, "frame start while finisher busy")
  `ROI_ASSERT(a_sqrt_onehot, clk, rst, state == F_SQRT |-> $onehot(sq_bit), "root probe bit lost")
  `ROI_ASSERT(a_empty_total, clk, rst, (out_valid && res.roi_empty) |-> res.pixel_total == '0, "empty result with pixels")

endmodule

FILE: src/roi_gray_statistics_unit.sv
// ---------------------------------------------------------------------------
// ROI gray statistics unit
// Mean and sample deviation of pixel averages, and extremes of channel samples, in a rectangle.
// ---------------------------------------------------------------------------
// Channel  Direction  Beat contents
// pix      in         four samples, end_of_line, end_of_frame
// res      out        mean_q8, stdev_q8, min_value, max_value, pixel_total, roi_empty
// cfg      in         register index and write data, always ready
//
// Pixels are taken one per cycle while pix.ready is high, through a three-stage
// lane and merge pipeline. An end-of-frame beat closes input until its result is
// built: it passes the pipeline, then the serial mean division, three multiplies,
// variance division and square root (partly skipped for an empty or single-pixel
// rectangle). A result waits in the output register while the next frame streams in.
// Reset is synchronous and clears position, sums and control state.
module roi_gray_statistics_unit import roi_gs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  roi_pix_if.sink   pix,
  roi_res_if.source res,
  roi_cfg_if.sink   cfg
);

  logic [COORD_BITS-1:0] roi_left, roi_top, column_pos, row_pos;
  logic [DIM_BITS-1:0]   roi_width, roi_height;
  logic [CC_BITS-1:0]    channel_count, cc, used;
  logic                  skip_alpha, signed_samples;
  logic                  accept, inroi, eof_busy, fin_busy, start;
  roi_snap_t             snap;

  logic [SAMPLE_BITS-1:0] raw [MAX_CHANNELS];
  val_t lane_val [MAX_CHANNELS];
  val_t lane_lo [MAX_CHANNELS];
  val_t lane_hi [MAX_CHANNELS];

  assign cfg.ready = 1'b1;
  assign pix.ready = !eof_busy && !fin_busy;
  assign accept    = pix.valid && pix.ready;

  assign cc   = (channel_count == '0) ? CC_BITS'(1) :
                (channel_count > CC_BITS'(MAX_CHANNELS)) ? CC_BITS'(MAX_CHANNELS) :
                channel_count;
  assign used = (cc == CC_BITS'(3) || (cc == CC_BITS'(4) && skip_alpha)) ? CC_BITS'(3) : cc;

  assign inroi = column_pos >= roi_left &&
                 {2'b0, column_pos} < {2'b0, roi_left} + {1'b0, roi_width} &&
                 row_pos >= roi_top &&
                 {2'b0, row_pos} < {2'b0, roi_top} + {1'b0, roi_height};

  assign raw[0] = pix.sample_a;
  assign raw[1] = pix.sample_b;
  assign raw[2] = pix.sample_c;
  assign raw[3] = pix.sample_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left       <= '0;
      roi_top        <= '0;
      roi_width      <= '0;
      roi_height     <= '0;
      channel_count  <= CC_BITS'(1);
      skip_alpha     <= 1'b0;
      signed_samples <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_ROI_LEFT:       roi_left       <= cfg.data[COORD_BITS-1:0];
        REG_ROI_TOP:        roi_top        <= cfg.data[COORD_BITS-1:0];
        REG_ROI_WIDTH:      roi_width      <= cfg.data[DIM_BITS-1:0];
        REG_ROI_HEIGHT:     roi_height     <= cfg.data[DIM_BITS-1:0];
        REG_CHANNEL_COUNT:  channel_count  <= cfg.data[CC_BITS-1:0];
        REG_SKIP_ALPHA:     skip_alpha     <= cfg.data[0];
        REG_SIGNED_SAMPLES: signed_samples <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos    <= '0;
    end else if (accept) begin
      if (pix.end_of_frame) begin
        column_pos <= '0;
        row_pos    <= '0;
      end else if (pix.end_of_line) begin
        column_pos <= '0;
        row_pos    <= row_pos + 1'b1;
      end else begin
        column_pos <= column_pos + 1'b1;
      end
    end
  end

  for (genvar k = 0; k < MAX_CHANNELS; k++) begin : g_lane
    roi_gs_lane u_lane (
      .clk         (clk),
      .load        (accept),
      .raw         (raw[k]),
      .signed_mode (signed_samples),
      .en          (CC_BITS'(k) < used),
      .val         (lane_val[k]),
      .lo          (lane_lo[k]),
      .hi          (lane_hi[k])
    );
  end

  roi_gs_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .inroi    (inroi),
    .eof      (pix.end_of_frame),
    .used     (used),
    .lane_val (lane_val),
    .lane_lo  (lane_lo),
    .lane_hi  (lane_hi),
    .eof_busy (eof_busy),
    .start    (start),
    .snap     (snap)
  );

  roi_gs_finish u_finish (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .snap  (snap),
    .busy  (fin_busy),
    .res   (res)
  );

endmodule

FILE: tb/sv/roi_gray_statistics_unit_test.sv
// ---------------------------------------------------------------------------
// ROI gray statistics unit testbench
// Streams raster frames through the pixel channel under a range of rectangle
// and channel settings, predicts each end-of-frame statistics beat and checks
// the result channel field by field, with random idling and a long hold-off.
// ---------------------------------------------------------------------------
module roi_gray_statistics_unit_test import roi_gs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int TARGET_PIXELS = 1050;
  localparam int HOLD_CYCLES = 3000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] a, b, c, d;
    logic                   eol, eof;
  } pixel_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0] mean;
    logic [DEV_BITS-1:0]  dev;
    logic [VAL_BITS-1:0]  mn, mx;
    logic [CNT_BITS-1:0]  total;
    logic                 empty;
  } stats_t;

  typedef struct {
    int      left, top, width, height, chans, skip, sgn;
    pixel_t  px;
    bit      typed;
    stats_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  roi_pix_if pix ();
  roi_res_if res ();
  roi_cfg_if cfg ();

  roi_gray_statistics_unit DUT (.clk(clk), .rst(rst), .pix(pix), .res(res), .cfg(cfg));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and register copy.
  int                   reg_left, reg_top, reg_width, reg_height, reg_chans, reg_skip, reg_sgn;
  logic [COORD_BITS-1:0] col_pos, row_pos;
  logic [SUM_BITS-1:0]  avg_sum;
  logic [SQ_BITS-1:0]   sq_sum;
  logic [CNT_BITS-1:0]  pix_count;
  longint               run_min, run_max;

  stats_t   stats_q[$];
  dir_row_t table_rows[$];
  int     fails = 0;
  int     cycles = 0;
  bit     calm = 1'b0;
  bit     hold_req = 1'b0;
  bit     hold_started = 1'b0;
  int     hold_left = 0;
  int     sent = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, bitv;
    root = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint sample_value(logic [SAMPLE_BITS-1:0] raw);
    if (reg_sgn != 0) return longint'($signed(raw));
    return longint'(raw);
  endfunction

  task automatic clear_frame_state();
    col_pos = '0;
    row_pos = '0;
    avg_sum = '0;
    sq_sum = '0;
    pix_count = '0;
    run_min = 65535;
    run_max = -32768;
  endtask

  task automatic add_row(input dir_row_t t);
    table_rows = {table_rows, t};
  endtask

  // Advances the statistics by one accepted pixel beat; returns the frame result
  // when the beat closes a frame.
  task automatic update_stats(input pixel_t p, output bit done, output stats_t r);
    int           chans, used;
    longint       s[4];
    longint       total, avg, mag, sval, mean, smag;
    logic signed [SUM_BITS-1:0] sum_s;
    logic [127:0] prod_a, prod_b, diff, quot;
    logic [63:0]  q, n, dev;
    chans = reg_chans == 0 ? 1 : (reg_chans > MAX_CHANNELS ? MAX_CHANNELS : reg_chans);
    used = (chans == 3 || (chans == 4 && reg_skip != 0)) ? 3 : chans;
    s[0] = sample_value(p.a);
    s[1] = sample_value(p.b);
    s[2] = sample_value(p.c);
    s[3] = sample_value(p.d);
    if (int'(col_pos) >= reg_left && int'(col_pos) < reg_left + reg_width &&
        int'(row_pos) >= reg_top && int'(row_pos) < reg_top + reg_height) begin
      total = 0;
      for (int k = 0; k < used; k++) begin
        total += s[k];
        if (s[k] < run_min) run_min = s[k];
        if (s[k] > run_max) run_max = s[k];
      end
      avg = total / longint'(used);
      mag = avg < 0 ? -avg : avg;
      avg_sum = avg_sum + SUM_BITS'(avg);
      sq_sum = sq_sum + SQ_BITS'(mag * mag);
      pix_count = pix_count + 1'b1;
    end
    if (p.eol) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    done = p.eof;
    r = '0;
    if (!p.eof) return;
    if (pix_count == 0) begin
      r.empty = 1'b1;
    end else begin
      n = 64'(pix_count);
      sum_s = avg_sum;
      sval = longint'(sum_s);
      smag = sval < 0 ? -sval : sval;
      mean = (sval * 256) / longint'(n);
      dev = '0;
      if (n > 1) begin
        prod_a = 128'(n) * 128'(sq_sum);
        prod_b = 128'(smag) * 128'(smag);
        if (prod_a >= prod_b) begin
          diff = prod_a - prod_b;
          if (diff[127:112] != 0) begin
            q = '1;
          end else begin
            quot = (diff << 16) / 128'(n * (n - 1));
            q = quot[127:64] != 0 ? '1 : quot[63:0];
          end
          dev = int_sqrt(q);
        end
      end
      if (dev > 64'hFF_FFFF) dev = 64'hFF_FFFF;
      r.mean = MEAN_BITS'(mean);
      r.dev = dev[DEV_BITS-1:0];
      r.mn = VAL_BITS'(run_min);
      r.mx = VAL_BITS'(run_max);
      r.total = pix_count;
    end
    clear_frame_state();
  endtask

  // Drives one pixel beat and waits for its acceptance.
  task automatic send_pixel(input pixel_t p);
    bit     done;
    stats_t r;
    if (!calm && $urandom_range(99) < 9) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.sample_a <= p.a;
    pix.sample_b <= p.b;
    pix.sample_c <= p.c;
    pix.sample_d <= p.d;
    pix.end_of_line <= p.eol;
    pix.end_of_frame <= p.eof;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sent++;
    update_stats(p, done, r);
    if (done) stats_q = {stats_q, r};
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes every register once; the block must be idle.
  task automatic write_regs(input int left, top, width, height, chans, skip, sgn);
    logic [CFG_IDX_BITS-1:0] idx[7];
    int                      val[7];
    idx = '{REG_ROI_LEFT, REG_ROI_TOP, REG_ROI_WIDTH, REG_ROI_HEIGHT,
            REG_CHANNEL_COUNT, REG_SKIP_ALPHA, REG_SIGNED_SAMPLES};
    val = '{left, top, width, height, chans, skip, sgn};
    drain();
    for (int k = 0; k < 7; k++) begin
      cfg.valid <= 1'b1;
      cfg.index <= idx[k];
      cfg.data <= CFG_DATA_BITS'(val[k]);
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
    end
    cfg.valid <= 1'b0;
    reg_left = left & 12'hFFF;
    reg_top = top & 12'hFFF;
    reg_width = width & 13'h1FFF;
    reg_height = height & 13'h1FFF;
    reg_chans = chans & 3'h7;
    reg_skip = skip & 1;
    reg_sgn = sgn & 1;
  endtask

  function automatic dir_row_t row(int left, top, width, height, chans, skip, sgn,
                                   logic [15:0] a, b, c, d, bit eol, eof,
                                   bit typed = 1'b0, stats_t want = '0);
    dir_row_t t;
    t.left = left; t.top = top; t.width = width; t.height = height;
    t.chans = chans; t.skip = skip; t.sgn = sgn;
    t.px = '{a: a, b: b, c: c, d: d, eol: eol, eof: eof};
    t.typed = typed;
    t.want = want;
    return t;
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (stats_q.size() == 0) begin
        $error("unexpected result beat");
        fails++;
      end else begin
        stats_t w;
        w = stats_q.pop_front();
        if (res.mean_q8 !== w.mean) begin
          $error("mean_q8 expected %h actual %h", w.mean, res.mean_q8); fails++;
        end
        if (res.stdev_q8 !== w.dev) begin
          $error("stdev_q8 expected %h actual %h", w.dev, res.stdev_q8); fails++;
        end
        if (res.min_value !== w.mn) begin
          $error("min_value expected %h actual %h", w.mn, res.min_value); fails++;
        end
        if (res.max_value !== w.mx) begin
          $error("max_value expected %h actual %h", w.mx, res.max_value); fails++;
        end
        if (res.pixel_total !== w.total) begin
          $error("pixel_total expected %h actual %h", w.total, res.pixel_total); fails++;
        end
        if (res.roi_empty !== w.empty) begin
          $error("roi_empty expected %b actual %b", w.empty, res.roi_empty); fails++;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 1'b0;
    end else if (hold_req && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= HOLD_CYCLES;
      res.ready <= 1'b0;
    end else begin
      res.ready <= calm || $urandom_range(99) >= 9;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    pixel_t   p;
    stats_t   want;
    int       w, h, mode, base, nframes;
    bit       noisy;
    int       left, top, width, height, chans, skip, sgn;

    pix.valid <= 1'b0;
    pix.sample_a <= '0; pix.sample_b <= '0; pix.sample_c <= '0; pix.sample_d <= '0;
    pix.end_of_line <= 1'b0; pix.end_of_frame <= 1'b0;
    cfg.valid <= 1'b0; cfg.index <= REG_ROI_LEFT; cfg.data <= '0;
    reg_left = 0; reg_top = 0; reg_width = 0; reg_height = 0;
    reg_chans = 1; reg_skip = 0; reg_sgn = 0;
    clear_frame_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // After reset the rectangle is empty.
    add_row(row(0, 0, 0, 0, 1, 0, 0, 16'h1234, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 0, 0, 1, 0, 0, 16'h0000, 0, 0, 0, 0, 1,
                1, '{0, 0, 0, 0, 0, 1'b1}));
    // Extreme single-pixel frames over the largest rectangle.
    want = '{25'h0FFFF00, 0, 17'h0FFFF, 17'h0FFFF, 1, 1'b0};
    add_row(row(0, 0, 4096, 4096, 1, 0, 0, 16'hFFFF, 0, 0, 0, 0, 1, 1, want));
    want = '{0, 0, 0, 0, 1, 1'b0};
    add_row(row(0, 0, 4096, 4096, 1, 0, 0, 16'h0000, 0, 0, 0, 1, 1, 1, want));
    want = '{25'h1800000, 0, 17'h18000, 17'h18000, 1, 1'b0};
    add_row(row(0, 0, 4096, 4096, 1, 0, 1, 16'h8000, 0, 0, 0, 0, 1, 1, want));
    // Negative sums truncate toward zero.
    add_row(row(0, 0, 4096, 4096, 1, 0, 1, 16'h7FFF, 0, 0, 0, 1, 0));
    add_row(row(0, 0, 4096, 4096, 1, 0, 1, 16'h8001, 0, 0, 0, 0, 0));
    add_row(row(0, 0, 4096, 4096, 1, 0, 1, 16'hFFFF, 0, 0, 0, 0, 1));
    // Three channels, alpha skipped, all four, two, and counts out of range.
    add_row(row(0, 0, 4096, 4096, 3, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFE, 0, 0, 0));
    add_row(row(0, 0, 4096, 4096, 3, 0, 0, 16'h0001, 0, 0, 16'hFFFF, 1, 0));
    add_row(row(0, 0, 4096, 4096, 3, 0, 0, 16'hFFFF, 0, 0, 16'hFFFF, 0, 1));
    add_row(row(0, 0, 4096, 4096, 3, 0, 1, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
    add_row(row(0, 0, 4096, 4096, 3, 0, 1, 16'hFFFE, 0, 0, 0, 0, 1));
    add_row(row(0, 0, 4096, 4096, 4, 1, 0, 10, 20, 30, 16'hFFFF, 0, 0));
    add_row(row(0, 0, 4096, 4096, 4, 1, 0, 0, 0, 0, 16'hFFFF, 0, 1));
    add_row(row(0, 0, 4096, 4096, 4, 0, 0, 10, 20, 30, 16'hFFFF, 0, 0));
    add_row(row(0, 0, 4096, 4096, 4, 0, 0, 0, 0, 0, 16'hFFFF, 0, 1));
    add_row(row(0, 0, 4096, 4096, 2, 1, 1, 16'hFFFF, 16'h0001, 7, 7, 1, 0));
    add_row(row(0, 0, 4096, 4096, 2, 1, 1, 16'h8000, 16'h7FFF, 7, 7, 0, 1));
    add_row(row(0, 0, 4096, 4096, 0, 0, 0, 5, 9, 9, 9, 0, 0));
    add_row(row(0, 0, 4096, 4096, 0, 0, 0, 7, 9, 9, 9, 0, 1));
    add_row(row(0, 0, 4096, 4096, 7, 0, 0, 1, 2, 3, 4, 0, 0));
    add_row(row(0, 0, 4096, 4096, 7, 0, 0, 4, 3, 2, 1, 0, 1));
    add_row(row(4095, 4095, 4096, 4096, 1, 0, 0, 16'hFFFF, 0, 0, 0, 1, 1,
                1, '{0, 0, 0, 0, 0, 1'b1}));

    foreach (table_rows[i]) begin
      if (table_rows[i].left != reg_left || table_rows[i].top != reg_top ||
          table_rows[i].width != reg_width || table_rows[i].height != reg_height ||
          table_rows[i].chans != reg_chans || table_rows[i].skip != reg_skip ||
          table_rows[i].sgn != reg_sgn)
        write_regs(table_rows[i].left, table_rows[i].top, table_rows[i].width,
                   table_rows[i].height, table_rows[i].chans, table_rows[i].skip,
                   table_rows[i].sgn);
      send_pixel(table_rows[i].px);
      // A typed expectation replaces the predicted one for the same frame.
      if (table_rows[i].typed) stats_q[stats_q.size() - 1] = table_rows[i].want;
    end

    while (sent < TARGET_PIXELS) begin
      left = $urandom_range(0, 5);
      top = $urandom_range(0, 3);
      width = $urandom_range(99) < 5 ? 4096 : $urandom_range(0, 9);
      height = $urandom_range(99) < 5 ? 4096 : $urandom_range(0, 6);
      if ($urandom_range(99) < 4) begin
        left = 4095;
        top = 4095;
      end
      chans = $urandom_range(0, 7);
      skip = $urandom_range(0, 1);
      sgn = $urandom_range(0, 1);
      write_regs(left, top, width, height, chans, skip, sgn);
      nframes = $urandom_range(1, 4);
      for (int f = 0; f < nframes; f++) begin
        calm = sent > 350 && sent < 470;
        if (sent > 600 && !hold_req) hold_req = 1'b1;
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 7);
        mode = $urandom_range(0, 2);
        base = $urandom;
        noisy = $urandom_range(99) < 12;
        for (int y = 0; y < h; y++) begin
          for (int x = 0; x < w; x++) begin
            if (mode == 0) begin
              p.a = $urandom; p.b = $urandom; p.c = $urandom; p.d = $urandom;
            end else begin
              p.a = 16'(base + $urandom_range(0, 40));
              p.b = 16'(base + $urandom_range(0, 40));
              p.c = 16'(base + $urandom_range(0, 40));
              p.d = 16'(base + $urandom_range(0, 40));
            end
            p.eol = noisy ? ($urandom_range(99) < 30) : (x == w - 1);
            p.eof = (x == w - 1) && (y == h - 1);
            if (p.eof && $urandom_range(1) == 0) p.eol = 1'b0;
            send_pixel(p);
          end
        end
      end
    end
    calm = 1'b0;
    drain();

    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: roi_gray_statistics_unit.f
+incdir+src
src/roi_gs_pkg.sv
src/roi_gs_ifs.sv
src/roi_gs_lane.sv
src/roi_gs_merge.sv
src/roi_gs_finish.sv
src/roi_gray_statistics_unit.sv
tb/sv/roi_gray_statistics_unit_test.sv
